>>> hw/rtl/rcd_pkg.sv
`timescale 1ns / 1ps

package rcd_pkg;

  localparam int FRAME_LEN = 18;
  localparam int POS_W = $clog2(FRAME_LEN + 1);
  localparam int QUEUE_DEPTH = 2;
  localparam logic [1:0] SW_UP = 2'd1;
  localparam logic [3:0] THRESHOLD_RESET = 4'd5;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       frame_start;
  } in_word_t;

  typedef struct packed {
    logic [10:0]        stick_ch0;
    logic [10:0]        stick_ch1;
    logic [10:0]        stick_ch2;
    logic [10:0]        stick_ch3;
    logic [10:0]        wheel_ch;
    logic [1:0]         raw_right;
    logic [1:0]         raw_left;
    logic signed [15:0] mouse_x;
    logic signed [15:0] mouse_y;
    logic signed [15:0] mouse_z;
    logic [15:0]        mouse_press;
    logic [15:0]        key_map;
  } frame_t;

  typedef struct packed {
    logic [10:0]        stick_ch0;
    logic [10:0]        stick_ch1;
    logic [10:0]        stick_ch2;
    logic [10:0]        stick_ch3;
    logic [10:0]        wheel_ch;
    logic [1:0]         right_sw;
    logic [1:0]         left_sw;
    logic signed [15:0] mouse_x;
    logic signed [15:0] mouse_y;
    logic signed [15:0] mouse_z;
    logic [15:0]        mouse_press;
    logic [15:0]        key_map;
  } out_word_t;

endpackage

>>> hw/rtl/rcd_front.sv
`timescale 1ns / 1ps

module rcd_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              byte_valid,
  input  rcd_pkg::in_word_t byte_word,
  output logic              frame_valid,
  output rcd_pkg::frame_t   frame
);

  localparam int STORE_LEN = rcd_pkg::FRAME_LEN - 1;

  logic [7:0]              store_r [STORE_LEN];
  logic [rcd_pkg::POS_W-1:0] pos_r;
  logic [rcd_pkg::POS_W-1:0] pos_nxt;
  logic [rcd_pkg::POS_W-1:0] pos_eff;
  logic                      in_frame;
  logic                      last_byte;
  logic [7:0]                b17;

  assign pos_eff   = byte_word.frame_start ? '0 : pos_r;
  assign in_frame  = pos_eff < rcd_pkg::POS_W'(rcd_pkg::FRAME_LEN);
  assign last_byte = pos_eff == rcd_pkg::POS_W'(STORE_LEN);

  always_comb begin
    pos_nxt = pos_r;
    if (byte_valid && in_frame) begin
      pos_nxt = pos_eff + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= rcd_pkg::POS_W'(rcd_pkg::FRAME_LEN);
    end else begin
      pos_r <= pos_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (byte_valid && in_frame && !last_byte) begin
      store_r[pos_eff] <= byte_word.rx_byte;
    end
  end

  // The final byte is taken straight from the input, so the frame is complete this cycle.
  assign b17         = byte_word.rx_byte;
  assign frame_valid = byte_valid && in_frame && last_byte;

  always_comb begin
    frame.stick_ch0   = {store_r[1][2:0], store_r[0]};
    frame.stick_ch1   = {store_r[2][5:0], store_r[1][7:3]};
    frame.stick_ch2   = {store_r[4][0], store_r[3], store_r[2][7:6]};
    frame.stick_ch3   = {store_r[5][3:0], store_r[4][7:1]};
    frame.wheel_ch    = {b17[2:0], store_r[16]};
    frame.raw_right   = store_r[5][5:4];
    frame.raw_left    = store_r[5][7:6];
    frame.mouse_x     = {store_r[7], store_r[6]};
    frame.mouse_y     = {store_r[9], store_r[8]};
    frame.mouse_z     = {store_r[11], store_r[10]};
    frame.mouse_press = {store_r[13], store_r[12]};
    frame.key_map     = {store_r[15], store_r[14]};
  end

endmodule

>>> hw/rtl/rcd_fifo.sv
`timescale 1ns / 1ps

module rcd_fifo #(
  parameter int DEPTH = rcd_pkg::QUEUE_DEPTH
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            wr_en,
  input  rcd_pkg::frame_t wr_data,
  output logic            full,
  input  logic            rd_en,
  output logic            empty,
  output rcd_pkg::frame_t rd_data
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  rcd_pkg::frame_t   mem_r [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r;
  logic [PTR_W-1:0]  wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r;
  logic [PTR_W-1:0]  rd_ptr_nxt;
  logic [CNT_W-1:0]  count_r;
  logic [CNT_W-1:0]  count_nxt;
  logic              do_wr;
  logic              do_rd;

  assign full    = count_r == CNT_W'(DEPTH);
  assign empty   = count_r == '0;
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_wr) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_rd) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_wr && !do_rd) begin
      count_nxt = count_r + 1'b1;
    end else if (do_rd && !do_wr) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

>>> hw/rtl/rcd_back.sv
`timescale 1ns / 1ps

module rcd_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [3:0]         threshold,
  input  logic               q_empty,
  input  rcd_pkg::frame_t    q_data,
  output logic               q_pop,
  output logic               empty,
  input  logic               pop,
  output rcd_pkg::out_word_t out_data
);

  logic              out_valid_r;
  logic              out_valid_nxt;
  rcd_pkg::out_word_t out_data_r;
  logic [1:0]        prev_right_r, prev_right_nxt;
  logic [1:0]        prev_left_r, prev_left_nxt;
  logic [3:0]        cnt_right_r, cnt_right_nxt;
  logic [3:0]        cnt_left_r, cnt_left_nxt;
  logic [1:0]        held_right_r, held_right_nxt;
  logic [1:0]        held_left_r, held_left_nxt;

  assign q_pop    = !q_empty && (!out_valid_r || pop);
  assign empty    = !out_valid_r;
  assign out_data = out_data_r;

  always_comb begin
    cnt_right_nxt = cnt_right_r;
    cnt_left_nxt  = cnt_left_r;
    if (q_data.raw_right == prev_right_r) begin
      if (cnt_right_r < threshold) begin
        cnt_right_nxt = cnt_right_r + 1'b1;
      end
    end else begin
      cnt_right_nxt = '0;
    end
    if (q_data.raw_left == prev_left_r) begin
      if (cnt_left_r < threshold) begin
        cnt_left_nxt = cnt_left_r + 1'b1;
      end
    end else begin
      cnt_left_nxt = '0;
    end
    held_right_nxt = (cnt_right_nxt >= threshold) ? q_data.raw_right : held_right_r;
    held_left_nxt  = (cnt_left_nxt >= threshold) ? q_data.raw_left : held_left_r;
    prev_right_nxt = q_data.raw_right;
    prev_left_nxt  = q_data.raw_left;
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (q_pop) begin
      out_valid_nxt = 1'b1;
    end else if (pop) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      prev_right_r <= rcd_pkg::SW_UP;
      prev_left_r  <= rcd_pkg::SW_UP;
      cnt_right_r  <= '0;
      cnt_left_r   <= '0;
      held_right_r <= rcd_pkg::SW_UP;
      held_left_r  <= rcd_pkg::SW_UP;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (q_pop) begin
        prev_right_r <= prev_right_nxt;
        prev_left_r  <= prev_left_nxt;
        cnt_right_r  <= cnt_right_nxt;
        cnt_left_r   <= cnt_left_nxt;
        held_right_r <= held_right_nxt;
        held_left_r  <= held_left_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      out_data_r.stick_ch0    <= q_data.stick_ch0;
      out_data_r.stick_ch1    <= q_data.stick_ch1;
      out_data_r.stick_ch2    <= q_data.stick_ch2;
      out_data_r.stick_ch3    <= q_data.stick_ch3;
      out_data_r.wheel_ch     <= q_data.wheel_ch;
      out_data_r.right_sw     <= held_right_nxt;
      out_data_r.left_sw      <= held_left_nxt;
      out_data_r.mouse_x      <= q_data.mouse_x;
      out_data_r.mouse_y      <= q_data.mouse_y;
      out_data_r.mouse_z      <= q_data.mouse_z;
      out_data_r.mouse_press  <= q_data.mouse_press;
      out_data_r.key_map      <= q_data.key_map;
    end
  end

endmodule

>>> hw/rtl/rc_dbus_frame_decoder.sv
`timescale 1ns / 1ps

// Decoder for 18-byte remote-control receiver frames. Push one received byte per word, with
// frame_start set on the first byte of each frame; a start flag always restarts the frame, and
// bytes after the eighteenth are dropped until the next start. The eighteenth byte produces one
// decoded word with the stick and wheel channels, mouse data, key bitmap and the two debounced
// switch positions. A byte is taken every cycle while full is low; full rises only when the
// two-frame queue between the byte assembler and the debounce stage is full, which happens only
// while the output word waits unpopped. A decoded word is written into the queue at the clock
// edge that accepts its last byte, and is registered into the output word when the debounce
// stage pops it from the queue. Write the debounce threshold only while no frame is in flight.
module rc_dbus_frame_decoder #(
  parameter int QUEUE_DEPTH = rcd_pkg::QUEUE_DEPTH
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  output logic               full,
  input  rcd_pkg::in_word_t  in_data,
  output logic               empty,
  input  logic               pop,
  output rcd_pkg::out_word_t out_data,
  input  logic               cfg_wr_en,
  input  logic [3:0]         cfg_wr_data
);

  logic [3:0]      thr_r;
  logic            byte_valid;
  logic            frame_valid;
  rcd_pkg::frame_t frame;
  logic            q_full;
  logic            q_empty;
  logic            q_pop;
  rcd_pkg::frame_t q_data;

  assign full       = q_full;
  assign byte_valid = push && !full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= rcd_pkg::THRESHOLD_RESET;
    end else if (cfg_wr_en) begin
      thr_r <= cfg_wr_data;
    end
  end

  rcd_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .byte_valid  (byte_valid),
    .byte_word   (in_data),
    .frame_valid (frame_valid),
    .frame       (frame)
  );

  rcd_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (frame_valid),
    .wr_data (frame),
    .full    (q_full),
    .rd_en   (q_pop),
    .empty   (q_empty),
    .rd_data (q_data)
  );

  rcd_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .threshold (thr_r),
    .q_empty   (q_empty),
    .q_data    (q_data),
    .q_pop     (q_pop),
    .empty     (empty),
    .pop       (pop),
    .out_data  (out_data)
  );

endmodule
